FILE: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that an implication holds at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Checks that a condition holds on the edge after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

FILE: rtl/tam_pkg.sv
`timescale 1ns / 1ps
package tam_pkg;

  typedef enum logic [1:0] {
    MODE_LOAD = 2'd0,
    MODE_SETPC = 2'd1,
    MODE_EXEC = 2'd2,
    MODE_NONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_DONE = 3'd0,
    ST_OUTPUT = 3'd1,
    ST_INPUT = 3'd2,
    ST_HALTED = 3'd3,
    ST_DIVZERO = 3'd4,
    ST_ILLEGAL = 3'd5,
    ST_BOUNDS = 3'd6
  } status_t;

  localparam logic [7:0] OP_ASSIGN = 8'd0;
  localparam logic [7:0] OP_ADD = 8'd1;
  localparam logic [7:0] OP_SUB = 8'd2;
  localparam logic [7:0] OP_MUL = 8'd3;
  localparam logic [7:0] OP_SDIV = 8'd4;
  localparam logic [7:0] OP_CMP = 8'd5;
  localparam logic [7:0] OP_IN = 8'd6;
  localparam logic [7:0] OP_OUT = 8'd7;
  localparam logic [7:0] OP_MUL2 = 8'd19;
  localparam logic [7:0] OP_UDIV = 8'd20;
  localparam logic [7:0] OP_IN2 = 8'd22;
  localparam logic [7:0] OP_OUTU = 8'd23;
  localparam logic [7:0] OP_GOTO = 8'd128;
  localparam logic [7:0] OP_JEQ = 8'd129;
  localparam logic [7:0] OP_JNE = 8'd130;
  localparam logic [7:0] OP_JLT = 8'd131;
  localparam logic [7:0] OP_JGE = 8'd132;
  localparam logic [7:0] OP_JGT = 8'd133;
  localparam logic [7:0] OP_JLE = 8'd134;
  localparam logic [7:0] OP_JULT = 8'd147;
  localparam logic [7:0] OP_JUGE = 8'd148;
  localparam logic [7:0] OP_JUGT = 8'd149;
  localparam logic [7:0] OP_JULE = 8'd150;
  localparam logic [7:0] OP_STOP = 8'd153;

  typedef enum logic [3:0] {
    S_IDLE, S_FETCH, S_DECODE, S_RDA2, S_EXEC, S_DIV, S_WRQ, S_WRR, S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic mem_wr_load;  // write the request's cell word
    logic rd_fetch;     // read instruction at pc
    logic rd_a1;        // read a1 operand (latch instruction)
    logic rd_a2;        // read a2 operand (latch x)
    logic latch_y;
    logic exec;         // perform the decoded operation
    logic div_start;
    logic div_step;
    logic wr_q;
    logic wr_r;
    logic set_pc;
    logic capture_in;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic halted;
  } stat_t;

  // Maps a conditional jump opcode to a flag index; 10 means not a jump.
  function automatic logic [3:0] flag_for(input logic [7:0] op);
    logic [3:0] f;
    unique case (op)
      OP_JEQ: f = 4'd0;
      OP_JNE: f = 4'd1;
      OP_JLT: f = 4'd2;
      OP_JGT: f = 4'd3;
      OP_JLE: f = 4'd4;
      OP_JGE: f = 4'd5;
      OP_JULT: f = 4'd6;
      OP_JUGT: f = 4'd7;
      OP_JULE: f = 4'd8;
      OP_JUGE: f = 4'd9;
      default: f = 4'd10;
    endcase
    return f;
  endfunction

endpackage

FILE: rtl/tam_ctrl.sv
`timescale 1ns / 1ps
module tam_ctrl
  import tam_pkg::*;
(
  input  logic   clk,
  input  logic   rst_n,
  input  logic   in_valid,
  input  logic   in_stall_req,
  input  mode_t  mode,
  input  logic   is_div,
  input  logic   div_ok,
  input  logic   out_busy,
  input  stat_t  stat,
  output logic   in_take,
  output logic   resp_fire,
  output cmd_t   cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_take = 1'b0;
    resp_fire = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall_req) begin
          in_take = 1'b1;
          cmd.capture_in = 1'b1;
          if (mode == MODE_LOAD) begin
            cmd.mem_wr_load = 1'b1;
            state_nxt = S_RESP;
          end else if (mode == MODE_SETPC) begin
            cmd.set_pc = 1'b1;
            state_nxt = S_RESP;
          end else if (mode == MODE_EXEC && !stat.halted) begin
            state_nxt = S_FETCH;
          end else begin
            state_nxt = S_RESP;
          end
        end
      end
      S_FETCH: begin
        cmd.rd_fetch = 1'b1;
        state_nxt = S_DECODE;
      end
      S_DECODE: begin
        cmd.rd_a1 = 1'b1;
        state_nxt = S_RDA2;
      end
      S_RDA2: begin
        cmd.rd_a2 = 1'b1;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        cmd.latch_y = 1'b1;
        cmd.exec = 1'b1;
        if (is_div && div_ok) begin
          cmd.div_start = 1'b1;
          state_nxt = S_DIV;
        end else begin
          state_nxt = S_RESP;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) state_nxt = S_WRQ;
      end
      S_WRQ: begin
        cmd.wr_q = 1'b1;
        state_nxt = S_WRR;
      end
      S_WRR: begin
        cmd.wr_r = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!out_busy) begin
          resp_fire = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/tam_dp.sv
`timescale 1ns / 1ps
module tam_dp
  import tam_pkg::*;
#(
  parameter int ADDR_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  input  logic [1:0]            in_mode,
  input  logic [15:0]           in_cell_address,
  input  logic [39:0]           in_cell_word,
  input  logic signed [31:0]    in_in_value,
  output logic                  is_div,
  output logic                  div_ok,
  output stat_t                 stat,
  output logic [2:0]            res_status,
  output logic [31:0]           res_value,
  output logic                  res_unsigned,
  output logic [15:0]           res_address,
  output logic [15:0]           res_pc
);

  localparam int DepthL = 1 << ADDR_BITS;
  localparam int CntW = $clog2(VALUE_BITS + 1);
  localparam logic [ADDR_BITS-1:0] ATop = {ADDR_BITS{1'b1}};

  logic [39:0] mem [DepthL];
  logic [39:0] rd_data_r;
  logic [ADDR_BITS-1:0] rd_addr;
  logic rd_en, wr_en;
  logic [ADDR_BITS-1:0] wr_addr;
  logic [39:0] wr_data;

  logic [ADDR_BITS-1:0] pc_r, pc_nxt;
  logic halted_r, halted_nxt;
  logic [9:0] flags_r, flags_nxt;
  logic [7:0] op_r;
  logic [ADDR_BITS-1:0] a1_r, a2_r;
  logic [VALUE_BITS-1:0] x_r, y;
  logic [VALUE_BITS-1:0] inv_r;

  logic [2:0] st_r, st_nxt;
  logic [31:0] oval_r, oval_nxt;
  logic ouns_r, ouns_nxt;
  logic [15:0] oaddr_r, oaddr_nxt;

  logic exec_wr;
  logic [VALUE_BITS-1:0] exec_val;

  // Divider state: restoring, one quotient bit a cycle.
  logic [VALUE_BITS-1:0] dq_r, dd_r;
  logic [VALUE_BITS:0] drem_r;
  logic [CntW-1:0] dcnt_r;
  logic dnegq_r, dnegr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture_in) begin
      inv_r <= in_in_value[VALUE_BITS-1:0];
    end
  end

  // Memory port mux.
  always_comb begin
    rd_en = cmd.rd_fetch | cmd.rd_a1 | cmd.rd_a2;
    rd_addr = pc_r;
    if (cmd.rd_a1) rd_addr = rd_data_r[16 +: ADDR_BITS];
    if (cmd.rd_a2) rd_addr = a2_r;
    wr_en = 1'b0;
    wr_addr = a1_r;
    wr_data = '0;
    if (cmd.mem_wr_load) begin
      wr_en = 1'b1;
      wr_addr = in_cell_address[ADDR_BITS-1:0];
      wr_data = in_cell_word;
    end else if (cmd.wr_q) begin
      wr_en = 1'b1;
      wr_data = 40'(dnegq_r ? (~dq_r + 1'b1) : dq_r);
    end else if (cmd.wr_r) begin
      wr_en = 1'b1;
      wr_addr = a1_r + 1'b1;
      wr_data = 40'(dnegr_r ? (~drem_r[VALUE_BITS-1:0] + 1'b1)
                            : drem_r[VALUE_BITS-1:0]);
    end else if (exec_wr) begin
      wr_en = 1'b1;
      wr_data = 40'(exec_val);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_a1) begin
      op_r <= rd_data_r[39:32];
      a1_r <= rd_data_r[16 +: ADDR_BITS];
      a2_r <= rd_data_r[0 +: ADDR_BITS];
    end
    if (cmd.rd_a2) x_r <= rd_data_r[VALUE_BITS-1:0];
  end
  assign y = rd_data_r[VALUE_BITS-1:0];

  logic [3:0] fi;
  logic [VALUE_BITS-1:0] sx, sy;

  assign is_div = (op_r == OP_SDIV) || (op_r == OP_UDIV);
  assign div_ok = (y != '0) && (a1_r != ATop);
  assign fi = flag_for(op_r);
  assign sx = x_r ^ {1'b1, {(VALUE_BITS-1){1'b0}}};
  assign sy = y ^ {1'b1, {(VALUE_BITS-1){1'b0}}};

  always_comb begin
    logic advance;
    exec_wr = 1'b0;
    exec_val = y;
    pc_nxt = pc_r;
    halted_nxt = halted_r;
    flags_nxt = flags_r;
    st_nxt = st_r;
    oval_nxt = oval_r;
    ouns_nxt = ouns_r;
    oaddr_nxt = oaddr_r;
    advance = 1'b1;
    if (cmd.capture_in) begin
      st_nxt = ST_DONE;
      oval_nxt = '0;
      ouns_nxt = 1'b0;
      oaddr_nxt = '0;
      if (in_mode == MODE_SETPC) begin
        pc_nxt = in_cell_address[ADDR_BITS-1:0];
        halted_nxt = 1'b0;
      end else if (in_mode == MODE_EXEC && halted_r) begin
        st_nxt = ST_HALTED;
      end
    end
    if (cmd.exec) begin
      if (fi < 4'd10) begin
        if (flags_r[fi]) begin
          pc_nxt = a1_r;
          advance = 1'b0;
        end
      end else begin
        case (op_r)
          OP_ASSIGN: exec_wr = 1'b1;
          OP_ADD: begin exec_wr = 1'b1; exec_val = x_r + y; end
          OP_SUB: begin exec_wr = 1'b1; exec_val = x_r - y; end
          OP_MUL, OP_MUL2: begin exec_wr = 1'b1; exec_val = x_r * y; end
          OP_SDIV, OP_UDIV: begin
            if (y == '0) begin
              st_nxt = ST_DIVZERO; halted_nxt = 1'b1; advance = 1'b0;
            end else if (a1_r == ATop) begin
              st_nxt = ST_BOUNDS; halted_nxt = 1'b1; advance = 1'b0;
            end
          end
          OP_CMP: begin
            flags_nxt = {x_r >= y, x_r <= y, x_r > y, x_r < y,
                         sx >= sy, sx <= sy, sx > sy, sx < sy,
                         x_r != y, x_r == y};
          end
          OP_IN, OP_IN2: begin
            exec_wr = 1'b1; exec_val = inv_r;
            st_nxt = ST_INPUT; oaddr_nxt = 16'(a1_r);
          end
          OP_OUT: begin
            oval_nxt = 32'($signed(x_r));
            st_nxt = ST_OUTPUT; oaddr_nxt = 16'(a1_r);
          end
          OP_OUTU: begin
            oval_nxt = 32'(x_r); ouns_nxt = 1'b1;
            st_nxt = ST_OUTPUT; oaddr_nxt = 16'(a1_r);
          end
          OP_GOTO: begin pc_nxt = a1_r; advance = 1'b0; end
          OP_STOP: begin st_nxt = ST_HALTED; halted_nxt = 1'b1; advance = 1'b0; end
          default: begin st_nxt = ST_ILLEGAL; halted_nxt = 1'b1; advance = 1'b0; end
        endcase
      end
      if (advance) begin
        if (pc_r == ATop) begin
          st_nxt = ST_BOUNDS; halted_nxt = 1'b1;
        end else begin
          pc_nxt = pc_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= '0;
      halted_r <= 1'b1;
      flags_r <= '0;
    end else begin
      pc_r <= pc_nxt;
      halted_r <= halted_nxt;
      flags_r <= flags_nxt;
    end
    st_r <= st_nxt;
    oval_r <= oval_nxt;
    ouns_r <= ouns_nxt;
    oaddr_r <= oaddr_nxt;
  end

  // Divider on magnitudes; signs fix up quotient and remainder at write-back.
  logic nx, ny;
  logic [VALUE_BITS-1:0] mx, my;
  logic [VALUE_BITS:0] trial;
  assign nx = (op_r == OP_SDIV) && x_r[VALUE_BITS-1];
  assign ny = (op_r == OP_SDIV) && y[VALUE_BITS-1];
  assign mx = nx ? (~x_r + 1'b1) : x_r;
  assign my = ny ? (~y + 1'b1) : y;
  assign trial = {drem_r[VALUE_BITS-1:0], dq_r[VALUE_BITS-1]} - {1'b0, dd_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_start) begin
      dcnt_r <= CntW'(VALUE_BITS - 1);
    end else if (cmd.div_step && dcnt_r != '0) begin
      dcnt_r <= dcnt_r - 1'b1;
    end
    if (cmd.div_start) begin
      dq_r <= mx;
      dd_r <= my;
      drem_r <= '0;
      dnegq_r <= nx ^ ny;
      dnegr_r <= nx;
    end else if (cmd.div_step) begin
      if (!trial[VALUE_BITS]) begin
        drem_r <= trial;
        dq_r <= {dq_r[VALUE_BITS-2:0], 1'b1};
      end else begin
        drem_r <= {drem_r[VALUE_BITS-1:0], dq_r[VALUE_BITS-1]};
        dq_r <= {dq_r[VALUE_BITS-2:0], 1'b0};
      end
    end
  end

  assign stat.div_last = (dcnt_r == '0);
  assign stat.halted = halted_r;

  assign res_status = st_r;
  assign res_value = oval_r;
  assign res_unsigned = ouns_r;
  assign res_address = oaddr_r;
  assign res_pc = 16'(pc_r);

endmodule

FILE: rtl/two_address_machine_step.sv
`timescale 1ns / 1ps
// Two-address machine step. Load and set-pc requests go straight from idle to the result state.
// Execute, unless halted, steps through fetch, decode, operand reads, execute and result states;
// divides add the bit-serial divider steps and the quotient and remainder writes.
// One request is in flight at a time; the output register frees on take.
// Synchronous active-low reset: pc 0, flags 0, halted set; memory is not cleared.
module two_address_machine_step
  import tam_pkg::*;
#(
  parameter int ADDR_BITS = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [15:0]        in_cell_address,
  input  logic [39:0]        in_cell_word,
  input  logic signed [31:0] in_in_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         out_status,
  output logic signed [31:0] out_out_value,
  output logic               out_out_unsigned,
  output logic [15:0]        out_out_address,
  output logic [15:0]        out_program_counter
);
`include "assert_macros.svh"

  cmd_t cmd;
  stat_t stat;
  mode_t mode;
  logic is_div, div_ok, in_take, resp_fire;
  logic out_valid_r;
  logic [2:0] rs;
  logic [31:0] rv;
  logic ru;
  logic [15:0] ra, rp;
  logic busy;

  assign busy = out_valid_r && out_stall;
  assign in_stall = 1'b0 | (!in_take);
  assign mode = mode_t'(in_mode);

  tam_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall_req(1'b0), .mode, .is_div, .div_ok,
    .out_busy(busy), .stat, .in_take, .resp_fire, .cmd
  );

  tam_dp #(.ADDR_BITS(ADDR_BITS), .VALUE_BITS(VALUE_BITS)) u_dp (
    .clk, .rst_n, .cmd, .in_mode, .in_cell_address, .in_cell_word,
    .in_in_value, .is_div, .div_ok, .stat, .res_status(rs),
    .res_value(rv), .res_unsigned(ru), .res_address(ra), .res_pc(rp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (resp_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
    if (resp_fire) begin
      out_status <= rs;
      out_out_value <= rv;
      out_out_unsigned <= ru;
      out_out_address <= ra;
      out_program_counter <= rp;
    end
  end
  assign out_valid = out_valid_r;

  `ASSERT_NEXT(a_resp_valid, clk, rst_n, resp_fire, out_valid)
  `ASSERT_IMPL(a_no_overwrite, clk, rst_n, resp_fire, !(out_valid_r && out_stall))
  `ASSERT_IMPL(a_take_once, clk, rst_n, in_take, !resp_fire)

endmodule
